[hw/rtl/srp_pkg.sv]
// shared types and constants for the skyline rectangle packer
// no dependencies; used by srp_cell and skyline_rectangle_packer_unit
package srp_pkg;

	localparam int DEF_MAX_PLATEAUS = 64;
	localparam int DEF_COORD_BITS   = 16;
	localparam int XW               = 16;

	localparam logic [15:0] RESET_BIN_WIDTH = 16'd1024;
	localparam logic [7:0]  RESET_MARGIN    = 8'd2;

	localparam logic [7:0] CFG_BIN_WIDTH = 8'd0;
	localparam logic [7:0] CFG_MARGIN    = 8'd1;

	typedef enum logic [1:0] {
		ST_PLACED  = 2'd0,
		ST_NO_FIT  = 2'd1,
		ST_FULL    = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef enum logic {
		CMD_CLEAR = 1'b0,
		CMD_PLACE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ALIGN,
		S_DECIDE,
		S_DEL,
		S_INS,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_ROT,
		OP_DEL,
		OP_INS,
		OP_CLR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     make;
	} cell_ctl_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] used_width;
		logic [15:0] used_height;
	} result_t;

endpackage

[hw/rtl/srp_cell.sv]
// one skyline plateau cell: start x and level, shifting with its neighbors
// depends on srp_pkg
module srp_cell #(
	parameter int IDX        = 0,
	parameter int PW         = 6,
	parameter int COORD_BITS = srp_pkg::DEF_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srp_pkg::cell_ctl_t    ctl,
	input  logic [PW-1:0]         pos,
	input  logic [15:0]           next_x,
	input  logic [COORD_BITS-1:0] next_y,
	input  logic [15:0]           prev_x,
	input  logic [COORD_BITS-1:0] prev_y,
	input  logic [15:0]           ins_x,
	input  logic [COORD_BITS-1:0] ins_y,
	input  logic [COORD_BITS-1:0] top,
	input  logic [7:0]            margin,
	output logic [15:0]           x,
	output logic [COORD_BITS-1:0] y
);

	logic [PW:0] idx_w;
	logic [PW:0] pos_w;
	logic        above;
	logic        at_ins;
	logic        at_pos;

	assign idx_w  = (PW+1)'(IDX);
	assign pos_w  = {1'b0, pos};
	assign above  = idx_w > pos_w;
	assign at_pos = idx_w == pos_w;
	assign at_ins = idx_w == pos_w + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x <= 16'(srp_pkg::RESET_MARGIN);
			y <= COORD_BITS'(srp_pkg::RESET_MARGIN);
		end else begin
			case (ctl.op)
				srp_pkg::OP_ROT: begin
					x <= next_x;
					y <= next_y;
				end
				srp_pkg::OP_DEL: begin
					if (above) begin
						x <= next_x;
						y <= next_y;
					end
				end
				srp_pkg::OP_INS: begin
					if (at_pos) begin
						y <= top;
					end else if (ctl.make && at_ins) begin
						x <= ins_x;
						y <= ins_y;
					end else if (ctl.make && above) begin
						x <= prev_x;
						y <= prev_y;
					end
				end
				srp_pkg::OP_CLR: begin
					if (IDX == 0) begin
						x <= 16'(margin);
						y <= COORD_BITS'(margin);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/skyline_rectangle_packer_unit.sv]
// skyline rectangle packer top level: control sequencer and ring of plateau cells
// depends on srp_pkg and srp_cell
// place: one full ring rotation per candidate plateau in the scan, then align, decide, delete
// the covered plateaus, insert the new one and finish
// clear goes straight to finish; one item at a time, next item taken while a result waits
// reset: one plateau at (2,2), bin width 1024, margin 2, extents zero, no result pending
module skyline_rectangle_packer_unit #(
	parameter int MAX_PLATEAUS = srp_pkg::DEF_MAX_PLATEAUS,
	parameter int COORD_BITS   = srp_pkg::DEF_COORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  srp_pkg::item_t   item,
	output logic             res_valid,
	input  logic             res_stall,
	output srp_pkg::result_t res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int N  = MAX_PLATEAUS;
	localparam int PW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int YW = COORD_BITS;
	localparam int TW = ((YW > 16) ? YW : 16) + 1;
	localparam logic [YW-1:0] YMAX = {YW{1'b1}};
	localparam logic [CW-1:0] NC   = CW'(N);

	srp_pkg::state_t    state_q, state_nx;
	srp_pkg::cell_ctl_t ctl;

	logic [15:0]   bin_width_q;
	logic [7:0]    margin_q;
	logic [15:0]   w_q, h_q;
	logic [PW-1:0] k_q, best_k_q;
	logic [CW-1:0] j_q, cnt_q, drp_q, best_drop_q;
	logic          found_q, run_q, fit_q, eq_q, best_eq_q, make_q;
	logic [15:0]   xk_q, best_x_q;
	logic [YW-1:0] lvl_q, best_y_q;
	logic [16:0]   edge_q;
	logic [15:0]   ext_w_q;
	logic [YW-1:0] ext_h_q;
	logic [1:0]    status_q;
	logic [15:0]   px_q, py_q;
	srp_pkg::result_t res_q;
	logic          res_valid_q;

	logic [15:0]   cx [N];
	logic [YW-1:0] cy [N];
	logic [15:0]   hx;
	logic [YW-1:0] hy;

	logic          accept, last_cand, inr, make_c, better;
	logic [16:0]   edge_c, best_edge;
	logic [17:0]   reach_c;
	logic [CW:0]   kj, n_c;
	logic [TW-1:0] top_w;
	logic [YW-1:0] top_c;
	logic [16:0]   uw_sum;
	logic [TW-1:0] uh_sum;

	assign hx = cx[0];
	assign hy = cy[0];

	assign accept     = item_valid && !item_stall;
	assign item_stall = state_q != srp_pkg::S_IDLE;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	assign edge_c    = {1'b0, hx} + {1'b0, w_q};
	assign reach_c   = {1'b0, edge_c} + 18'(margin_q);
	assign kj        = (CW+1)'(k_q) + (CW+1)'(j_q);
	assign inr       = (j_q != '0) && (kj < {1'b0, cnt_q}) && run_q;
	assign last_cand = (CW'(k_q) + 1'b1) == cnt_q;
	assign better    = fit_q && (!found_q || lvl_q < best_y_q);

	assign best_edge = {1'b0, best_x_q} + {1'b0, w_q};
	assign make_c    = !best_eq_q && (best_edge + 17'(margin_q) != {1'b0, bin_width_q});
	assign n_c       = {1'b0, cnt_q} - {1'b0, best_drop_q} + (CW+1)'(make_c);

	assign top_w = TW'(best_y_q) + TW'(h_q);
	assign top_c = (top_w > TW'(YMAX)) ? YMAX : top_w[YW-1:0];

	assign uw_sum = {1'b0, ext_w_q} + 17'(margin_q);
	assign uh_sum = TW'(ext_h_q) + TW'(margin_q);

	// plateau ring
	for (genvar i = 0; i < N; i++) begin : g_cell
		srp_cell #(
			.IDX(i),
			.PW(PW),
			.COORD_BITS(YW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.pos(best_k_q),
			.next_x(cx[(i + 1) % N]),
			.next_y(cy[(i + 1) % N]),
			.prev_x(cx[(i + N - 1) % N]),
			.prev_y(cy[(i + N - 1) % N]),
			.ins_x(best_edge[15:0]),
			.ins_y(best_y_q),
			.top(top_c),
			.margin(margin_q),
			.x(cx[i]),
			.y(cy[i])
		);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			srp_pkg::S_IDLE: begin
				if (accept) begin
					state_nx = (item.cmd == srp_pkg::CMD_CLEAR) ? srp_pkg::S_FIN
						: srp_pkg::S_SCAN;
				end
			end
			srp_pkg::S_SCAN: begin
				if (j_q == NC && last_cand) begin
					state_nx = (cnt_q == NC) ? srp_pkg::S_DECIDE : srp_pkg::S_ALIGN;
				end
			end
			srp_pkg::S_ALIGN: begin
				if (j_q == NC - 1'b1) begin
					state_nx = srp_pkg::S_DECIDE;
				end
			end
			srp_pkg::S_DECIDE: begin
				if (!found_q || w_q == '0 || n_c > (CW+1)'(N)) begin
					state_nx = srp_pkg::S_FIN;
				end else begin
					state_nx = srp_pkg::S_DEL;
				end
			end
			srp_pkg::S_DEL: begin
				if (drp_q == '0) begin
					state_nx = srp_pkg::S_INS;
				end
			end
			srp_pkg::S_INS: state_nx = srp_pkg::S_FIN;
			srp_pkg::S_FIN: begin
				if (!res_valid_q || !res_stall) begin
					state_nx = srp_pkg::S_IDLE;
				end
			end
			default: state_nx = srp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.op   = srp_pkg::OP_HOLD;
		ctl.make = make_q;
		unique case (state_q)
			srp_pkg::S_IDLE: begin
				if (accept && item.cmd == srp_pkg::CMD_CLEAR) begin
					ctl.op = srp_pkg::OP_CLR;
				end
			end
			srp_pkg::S_SCAN, srp_pkg::S_ALIGN: ctl.op = srp_pkg::OP_ROT;
			srp_pkg::S_DEL: begin
				if (drp_q != '0) begin
					ctl.op = srp_pkg::OP_DEL;
				end
			end
			srp_pkg::S_INS: ctl.op = srp_pkg::OP_INS;
			default: ctl.op = srp_pkg::OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srp_pkg::S_IDLE;
			bin_width_q <= srp_pkg::RESET_BIN_WIDTH;
			margin_q    <= srp_pkg::RESET_MARGIN;
			cnt_q       <= CW'(1);
			ext_w_q     <= '0;
			ext_h_q     <= '0;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			j_q         <= '0;
			k_q         <= '0;
			drp_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					srp_pkg::CFG_BIN_WIDTH: bin_width_q <= cfg_data;
					srp_pkg::CFG_MARGIN:    margin_q    <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (res_valid_q && !res_stall && state_q != srp_pkg::S_FIN) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				srp_pkg::S_IDLE: begin
					if (accept) begin
						w_q     <= item.rect_width;
						h_q     <= item.rect_height;
						k_q     <= '0;
						j_q     <= '0;
						found_q <= 1'b0;
						px_q    <= '0;
						py_q    <= '0;
						if (item.cmd == srp_pkg::CMD_CLEAR) begin
							cnt_q    <= CW'(1);
							ext_w_q  <= '0;
							ext_h_q  <= '0;
							status_q <= srp_pkg::ST_CLEARED;
						end
					end
				end
				srp_pkg::S_SCAN: begin
					if (j_q == '0) begin
						xk_q   <= hx;
						lvl_q  <= hy;
						edge_q <= edge_c;
						fit_q  <= reach_c <= {2'b0, bin_width_q};
						drp_q  <= '0;
						eq_q   <= 1'b0;
						run_q  <= 1'b1;
						j_q    <= j_q + 1'b1;
					end else if (j_q != NC) begin
						if (inr) begin
							if ({1'b0, hx} < edge_q) begin
								lvl_q <= (hy > lvl_q) ? hy : lvl_q;
								drp_q <= drp_q + 1'b1;
							end else begin
								run_q <= 1'b0;
								eq_q  <= {1'b0, hx} == edge_q;
							end
						end
						j_q <= j_q + 1'b1;
					end else begin
						if (better) begin
							found_q     <= 1'b1;
							best_k_q    <= k_q;
							best_x_q    <= xk_q;
							best_y_q    <= lvl_q;
							best_drop_q <= drp_q;
							best_eq_q   <= eq_q;
						end
						k_q <= k_q + 1'b1;
						j_q <= last_cand ? cnt_q : '0;
					end
				end
				srp_pkg::S_ALIGN: j_q <= j_q + 1'b1;
				srp_pkg::S_DECIDE: begin
					make_q <= make_c;
					drp_q  <= best_drop_q;
					if (!found_q) begin
						status_q <= srp_pkg::ST_NO_FIT;
					end else if (w_q == '0) begin
						status_q <= srp_pkg::ST_PLACED;
						px_q     <= best_x_q;
						py_q     <= 16'(best_y_q);
					end else begin
						status_q <= srp_pkg::ST_FULL;
					end
				end
				srp_pkg::S_DEL: begin
					if (drp_q != '0) begin
						drp_q <= drp_q - 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				srp_pkg::S_INS: begin
					cnt_q    <= cnt_q + CW'(make_q);
					status_q <= srp_pkg::ST_PLACED;
					px_q     <= best_x_q;
					py_q     <= 16'(best_y_q);
					if (best_edge[15:0] > ext_w_q) begin
						ext_w_q <= best_edge[15:0];
					end
					if (top_c > ext_h_q) begin
						ext_h_q <= top_c;
					end
				end
				srp_pkg::S_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q       <= 1'b1;
						res_q.status      <= status_q;
						res_q.pos_x       <= px_q;
						res_q.pos_y       <= py_q;
						res_q.used_width  <= uw_sum[16] ? 16'hFFFF : uw_sum[15:0];
						res_q.used_height <= (uh_sum > TW'(16'hFFFF)) ? 16'hFFFF
							: uh_sum[15:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= NC)
		else $error("plateau count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == srp_pkg::S_FIN)
		else $error("result raised outside finish");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd == srp_pkg::CMD_CLEAR |=> cnt_q == CW'(1) && ext_w_q == '0)
		else $error("clear did not reset skyline");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srp_pkg::S_SCAN |-> j_q <= NC)
		else $error("scan step counter overran");

endmodule
